@@ design/sce_pkg.sv @@
// Shared types, constants and helper function of the stuffed CRC frame encoder.
package sce_pkg;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [7:0]  HEAD_BYTE     = 8'h55;
   localparam logic [7:0]  ESC_BYTE      = 8'h56;
   localparam logic [7:0]  ESC_HEAD      = 8'h56;
   localparam logic [7:0]  ESC_ESC       = 8'h57;
   localparam logic [15:0] CRC_POLY_RST  = 16'h1021;
   localparam logic [3:0]  FRAME_NUM_MAX = 4'd15;
   localparam logic [3:0]  FRAME_NUM_MIN = 4'd1;

   // register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] REG_BUS_ADDRESS    = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PRIORITY_CODE  = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ANSWER_CODE    = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CRC_POLYNOMIAL = 8'd3;

   // byte slot of the frame being sent, one-hot
   typedef enum logic [6:0] {
      SLOT_HEAD = 7'b0000001,
      SLOT_ADDR = 7'b0000010,
      SLOT_CTRL = 7'b0000100,
      SLOT_LEN  = 7'b0001000,
      SLOT_DATA = 7'b0010000,
      SLOT_CRCH = 7'b0100000,
      SLOT_CRCL = 7'b1000000
   } slot_type;

   // one request as held by the buffer and the output sequencer
   typedef struct packed {
      logic [7:0] value;
      logic [7:0] length;
      logic [3:0] frame_num;
      logic       is_cmd;
      logic       finish;
   } job_type;

   // MSB-first CRC-16 over one byte, no reflection
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                              input logic [7:0]  data,
                                              input logic [15:0] poly);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ poly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ design/sce_req_if.sv @@
// Request channel of the frame encoder: command or payload byte plus length.
interface sce_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic [7:0] payload_length;

   modport source (output valid, output byte_value, output payload_length, input ready);
   modport sink   (input valid, input byte_value, input payload_length, output ready);
endinterface

@@ design/sce_rsp_if.sv @@
// Result channel of the frame encoder: one wire byte per transfer.
interface sce_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       frame_end;
   logic       run_last;

   modport source (output valid, output out_byte, output frame_end, output run_last,
                   input ready);
   modport sink   (input valid, input out_byte, input frame_end, input run_last,
                   output ready);
endinterface

@@ design/stuffed_crc_frame_encoder_top.sv @@
// Stuffed CRC-16 frame encoder: requests in, byte-stuffed frame bytes out.
//
// A request taken while no frame is open is a command: it opens a frame and
// gives head 0x55, bus address, control byte, length plus one and the command
// byte, and, for a zero length, the CRC too (5 to 13 output bytes). Each later
// request carries one payload byte (1 or 2 output bytes), the last one also
// followed by the CRC, high byte first (3 to 6 bytes in all). Every byte after
// the head that equals 0x55 or 0x56 goes out escaped as two bytes. The output
// sequencer sends one byte per cycle while the result side is ready; a request
// gives at least one output byte, and plain payload streams run at one request
// per cycle under that same condition. A one-entry request buffer in front of the
// sequencer takes the next request while the current one is still being sent,
// and req ready depends on that buffer only. The CRC is advanced by one byte
// as the first wire byte of each body byte leaves, so its high byte is ready when
// its slot comes up. Configuration is expected to change only between frames.
module stuffed_crc_frame_encoder_top
   import sce_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   sce_req_if.sink                req_ch,
   sce_rsp_if.source              rsp_ch,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   logic [7:0]  bus_address_ff;
   logic [7:0]  priority_code_ff;
   logic [7:0]  answer_code_ff;
   logic [15:0] crc_poly_ff;

   // request-side frame tracking
   logic        in_frame_ff,  in_frame_in;
   logic [7:0]  remain_ff,    remain_in;
   logic [3:0]  frame_num_ff, frame_num_in;

   // request buffer and active job
   logic        pend_valid_ff, pend_valid_in;
   job_type     pend_ff,       pend_in;
   logic        act_valid_ff,  act_valid_in;
   job_type     act_ff,        act_in;
   slot_type    slot_ff,       slot_in;
   logic        esc_ff,        esc_in;
   logic [15:0] crc_ff,        crc_in;

   logic        req_hs, rsp_hs;
   job_type     req_job;
   logic [7:0]  remain_dec;
   logic [7:0]  slot_byte;
   logic        needs_stuff, last_phase, job_last, act_free, body_slot;
   slot_type    slot_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_address_ff   <= '0;
         priority_code_ff <= '0;
         answer_code_ff   <= '0;
         crc_poly_ff      <= CRC_POLY_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_BUS_ADDRESS:    bus_address_ff   <= csr_wdata[7:0];
            REG_PRIORITY_CODE:  priority_code_ff <= csr_wdata[7:0];
            REG_ANSWER_CODE:    answer_code_ff   <= csr_wdata[7:0];
            REG_CRC_POLYNOMIAL: crc_poly_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ch.ready = !pend_valid_ff;
   assign req_hs       = req_ch.valid && !pend_valid_ff;
   assign rsp_hs       = act_valid_ff && rsp_ch.ready;

   // classify the incoming request against the open frame
   always_comb begin
      remain_dec   = remain_ff - 8'd1;
      in_frame_in  = in_frame_ff;
      remain_in    = remain_ff;
      frame_num_in = frame_num_ff;
      req_job.value     = req_ch.byte_value;
      req_job.length    = req_ch.payload_length;
      req_job.is_cmd    = !in_frame_ff;
      req_job.frame_num = (frame_num_ff == FRAME_NUM_MAX) ? FRAME_NUM_MIN
                                                          : frame_num_ff + 4'd1;
      if (!in_frame_ff) begin
         req_job.finish = (req_ch.payload_length == 8'd0);
      end else begin
         req_job.finish = (remain_dec == 8'd0);
      end
      if (req_hs) begin
         if (!in_frame_ff) begin
            frame_num_in = req_job.frame_num;
            remain_in    = req_ch.payload_length;
         end else begin
            remain_in    = remain_dec;
         end
         in_frame_in = !req_job.finish;
      end
   end

   // logical byte of the current slot and its escape handling
   always_comb begin
      unique case (slot_ff)
         SLOT_HEAD: slot_byte = HEAD_BYTE;
         SLOT_ADDR: slot_byte = bus_address_ff;
         SLOT_CTRL: slot_byte = priority_code_ff + answer_code_ff + {4'd0, act_ff.frame_num};
         SLOT_LEN:  slot_byte = act_ff.length + 8'd1;
         SLOT_DATA: slot_byte = act_ff.value;
         SLOT_CRCH: slot_byte = crc_ff[15:8];
         SLOT_CRCL: slot_byte = crc_ff[7:0];
         default:   slot_byte = act_ff.value;
      endcase
      unique case (slot_ff)
         SLOT_HEAD: slot_next = SLOT_ADDR;
         SLOT_ADDR: slot_next = SLOT_CTRL;
         SLOT_CTRL: slot_next = SLOT_LEN;
         SLOT_LEN:  slot_next = SLOT_DATA;
         SLOT_DATA: slot_next = SLOT_CRCH;
         SLOT_CRCH: slot_next = SLOT_CRCL;
         SLOT_CRCL: slot_next = SLOT_CRCL;
         default:   slot_next = SLOT_CRCL;
      endcase
      needs_stuff = (slot_ff != SLOT_HEAD)
                    && (slot_byte == HEAD_BYTE || slot_byte == ESC_BYTE);
      last_phase  = esc_ff || !needs_stuff;
      body_slot   = (slot_ff == SLOT_ADDR) || (slot_ff == SLOT_CTRL)
                    || (slot_ff == SLOT_LEN) || (slot_ff == SLOT_DATA);
      job_last    = last_phase && ((slot_ff == SLOT_CRCL)
                    || (slot_ff == SLOT_DATA && !act_ff.finish));
   end

   assign rsp_ch.valid     = act_valid_ff;
   assign rsp_ch.out_byte  = !needs_stuff ? slot_byte
                           : !esc_ff      ? ESC_BYTE
                           : (slot_byte == HEAD_BYTE) ? ESC_HEAD : ESC_ESC;
   assign rsp_ch.frame_end = (slot_ff == SLOT_CRCL) && last_phase;
   assign rsp_ch.run_last  = job_last;

   assign act_free = !act_valid_ff || (rsp_hs && job_last);

   // sequencer, buffer and CRC next state
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      act_valid_in  = act_valid_ff;
      act_in        = act_ff;
      slot_in       = slot_ff;
      esc_in        = esc_ff;
      crc_in        = crc_ff;

      // CRC takes each body byte as its first wire byte leaves; a command
      // restarts it from zero at the address byte
      if (rsp_hs && body_slot && !esc_ff) begin
         crc_in = crc16_byte((act_ff.is_cmd && slot_ff == SLOT_ADDR) ? 16'h0000 : crc_ff,
                             slot_byte, crc_poly_ff);
      end

      if (rsp_hs && !job_last) begin
         if (!last_phase) begin
            esc_in = 1'b1;
         end else begin
            esc_in  = 1'b0;
            slot_in = slot_next;
         end
      end

      if (act_free) begin
         esc_in = 1'b0;
         if (pend_valid_ff) begin
            act_valid_in  = 1'b1;
            act_in        = pend_ff;
            slot_in       = pend_ff.is_cmd ? SLOT_HEAD : SLOT_DATA;
            pend_valid_in = 1'b0;
         end else if (req_hs) begin
            act_valid_in = 1'b1;
            act_in       = req_job;
            slot_in      = req_job.is_cmd ? SLOT_HEAD : SLOT_DATA;
         end else begin
            act_valid_in = 1'b0;
         end
      end else if (req_hs) begin
         pend_valid_in = 1'b1;
         pend_in       = req_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         remain_ff     <= '0;
         frame_num_ff  <= '0;
         pend_valid_ff <= 1'b0;
         act_valid_ff  <= 1'b0;
         slot_ff       <= SLOT_HEAD;
         esc_ff        <= 1'b0;
         crc_ff        <= '0;
      end else begin
         in_frame_ff   <= in_frame_in;
         remain_ff     <= remain_in;
         frame_num_ff  <= frame_num_in;
         pend_valid_ff <= pend_valid_in;
         act_valid_ff  <= act_valid_in;
         slot_ff       <= slot_in;
         esc_ff        <= esc_in;
         crc_ff        <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      act_ff  <= act_in;
   end

   // buffer only fills behind a busy sequencer
   a_pend_needs_act: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> act_valid_ff)
      else $error("request buffer full with sequencer idle");

   // the sequencer is always busy in the next cycle after an accepted request
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_hs |=> act_valid_ff)
      else $error("accepted request not picked up by sequencer");

   // frame end is always the last byte of its request
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.frame_end |-> rsp_ch.run_last)
      else $error("frame end without run last");

   // second half of an escape follows an escape byte that was taken
   a_esc_follows: assert property (@(posedge clock) disable iff (reset)
      $rose(esc_ff) |-> $past(rsp_hs) && $past(rsp_ch.out_byte) == ESC_BYTE)
      else $error("escape phase without a sent escape byte");

endmodule

@@ test/tb_stuffed_crc_frame_encoder_top.sv @@
// Self-checking testbench of the stuffed CRC-16 frame encoder top level.
`timescale 1ns / 1ps

module tb_stuffed_crc_frame_encoder_top;
   import sce_pkg::*;

   // index with no register behind it, writes to it must change nothing
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 8'd4;

   // one request as queued for the driver
   typedef struct packed {
      logic [7:0] value;
      logic [7:0] length;
   } req_item_type;

   // one byte of the predicted wire stream
   typedef struct packed {
      logic [7:0] data;
      logic       frame_end;
      logic       run_last;
   } wire_byte_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   sce_req_if req_if ();
   sce_rsp_if rsp_if ();

   stuffed_crc_frame_encoder_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Predictor state: register copies and frame state of the encoder
   // ---------------------------------------------------------------------
   logic [7:0]  addr_reg;
   logic [7:0]  prio_reg;
   logic [7:0]  answer_reg;
   logic [15:0] poly_reg;

   logic [3:0]  frame_num_q;
   logic [15:0] crc_q;
   logic [7:0]  left_q;
   logic        frame_open;

   wire_byte_type wire_bytes_due[$];   // predicted wire bytes, oldest first
   req_item_type  req_backlog[$];      // requests waiting for the driver

   int requests_queued;
   int requests_taken;
   int frames_queued;
   int settings_done;
   int bytes_checked;
   int err_cnt;

   logic req_taken;                  // request accepted at the last rising edge
   logic quiet;                      // no new random idle bursts on either side once set
   int   send_gap;
   int   hold_gap;

   // 20 ns clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // bit-serial MSB-first CRC-16, one data bit per step
   function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] data,
                                            input logic [15:0] poly);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ data[i];
         r  = {r[14:0], 1'b0};
         if (fb) begin
            r = r ^ poly;
         end
      end
      return r;
   endfunction

   function automatic void emit_wire(input logic [7:0] b);
      wire_byte_type w;
      w.data      = b;
      w.frame_end = 1'b0;
      w.run_last  = 1'b0;
      wire_bytes_due.push_back(w);
   endfunction

   // head and escape bytes after the head go out as two-byte escapes
   function automatic void emit_escaped(input logic [7:0] b);
      if (b == HEAD_BYTE) begin
         emit_wire(ESC_BYTE);
         emit_wire(ESC_HEAD);
      end else if (b == ESC_BYTE) begin
         emit_wire(ESC_BYTE);
         emit_wire(ESC_ESC);
      end else begin
         emit_wire(b);
      end
   endfunction

   function automatic void emit_body(input logic [7:0] b);
      crc_q = crc_next(crc_q, b, poly_reg);
      emit_escaped(b);
   endfunction

   // CRC high byte then low byte, the low one flagged as frame end
   function automatic void close_frame();
      wire_byte_type w;
      emit_escaped(crc_q[15:8]);
      emit_escaped(crc_q[7:0]);
      w = wire_bytes_due.pop_back();
      w.frame_end = 1'b1;
      wire_bytes_due.push_back(w);
      frame_open = 1'b0;
      left_q     = 8'd0;
   endfunction

   // works out the wire bytes that one accepted request causes
   function automatic void encode_request(input logic [7:0] value, input logic [7:0] length);
      wire_byte_type w;
      if (!frame_open) begin
         frame_num_q = (frame_num_q == FRAME_NUM_MAX) ? FRAME_NUM_MIN : frame_num_q + 4'd1;
         crc_q = 16'h0000;
         emit_wire(HEAD_BYTE);
         emit_body(addr_reg);
         emit_body(prio_reg + answer_reg + {4'h0, frame_num_q});
         emit_body(length + 8'd1);   // length 255 wraps to zero here
         emit_body(value);
         left_q     = length;
         frame_open = 1'b1;
         if (left_q == 8'd0) begin
            close_frame();
         end
      end else begin
         // payload request: its length field means nothing
         emit_body(value);
         left_q = left_q - 8'd1;
         if (left_q == 8'd0) begin
            close_frame();
         end
      end
      w = wire_bytes_due.pop_back();
      w.run_last = 1'b1;
      wire_bytes_due.push_back(w);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      err_cnt++;
   endtask

   // ---------------------------------------------------------------------
   // Rising edge: take accepted requests into the predictor, then check
   // every accepted wire byte against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      wire_byte_type due;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            req_taken = 1'b1;
            requests_taken++;
            encode_request(req_if.byte_value, req_if.payload_length);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (wire_bytes_due.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h end %b last %b",
                                         rsp_if.out_byte, rsp_if.frame_end, rsp_if.run_last));
            end else begin
               due = wire_bytes_due.pop_front();
               if (rsp_if.out_byte !== due.data || rsp_if.frame_end !== due.frame_end ||
                   rsp_if.run_last !== due.run_last) begin
                  report_mismatch($sformatf(
                     "byte %0d: got %02h end %b last %b, expected %02h end %b last %b",
                     bytes_checked, rsp_if.out_byte, rsp_if.frame_end, rsp_if.run_last,
                     due.data, due.frame_end, due.run_last));
               end
               bytes_checked++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request driver: falling edge, holds a request until it is taken,
   // idles in random bursts unless quiet
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      req_item_type nxt;
      logic         offer;
      offer     = 1'b0;
      nxt.value  = 8'($urandom);
      nxt.length = 8'($urandom);
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (req_backlog.size() != 0) begin
            if (!quiet && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(0, 11);
            end else begin
               nxt   = req_backlog.pop_front();
               offer = 1'b1;
            end
         end
         // junk on the payload while nothing is offered
         req_if.valid          <= offer;
         req_if.byte_value     <= nxt.value;
         req_if.payload_length <= nxt.length;
      end
   end

   // result side back-pressure, same burst pattern
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_gap > 0) begin
         hold_gap--;
         rsp_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         hold_gap = $urandom_range(0, 11);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // byte values with the head and escape codes and the extremes weighted up
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return HEAD_BYTE;
         1:       return ESC_BYTE;
         2:       return 8'h00;
         3:       return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic push_request(input logic [7:0] value, input logic [7:0] length);
      req_item_type r;
      r.value  = value;
      r.length = length;
      req_backlog.push_back(r);
      requests_queued++;
   endtask

   // command request plus its payload requests, junk in the ignored length
   task automatic queue_frame(input logic [7:0] cmd, input logic [7:0] length);
      push_request(cmd, length);
      for (int i = 0; i < int'(length); i++) begin
         push_request(pick_byte(), 8'($urandom));
      end
      frames_queued++;
   endtask

   // hold the sender back until every request is taken and every byte seen
   task automatic settle();
      while (requests_taken != requests_queued || wire_bytes_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0]  val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_BUS_ADDRESS:    addr_reg   = val[7:0];
         REG_PRIORITY_CODE:  prio_reg   = val[7:0];
         REG_ANSWER_CODE:    answer_reg = val[7:0];
         REG_CRC_POLYNOMIAL: poly_reg   = val;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Stimulus: directed frames under reset settings, then random phases,
   // each phase starting from an idle block with fresh register values
   // ---------------------------------------------------------------------
   initial begin
      logic [7:0]  a;
      logic [7:0]  p;
      logic [7:0]  an;
      logic [15:0] poly;
      int          target;

      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_index             = '0;
      csr_wdata             = '0;
      req_if.valid          = 1'b0;
      req_if.byte_value     = 8'h00;
      req_if.payload_length = 8'h00;
      rsp_if.ready          = 1'b0;
      req_taken             = 1'b0;
      quiet                 = 1'b0;
      send_gap              = 0;
      hold_gap              = 0;
      requests_queued       = 0;
      requests_taken        = 0;
      frames_queued         = 0;
      settings_done         = 1;
      bytes_checked         = 0;
      err_cnt               = 0;

      addr_reg    = 8'h00;
      prio_reg    = 8'h00;
      answer_reg  = 8'h00;
      poly_reg    = CRC_POLY_RST;
      frame_num_q = 4'd0;
      crc_q       = 16'h0000;
      left_q      = 8'd0;
      frame_open  = 1'b0;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // zero-length frames, extreme and escaped command bytes
      push_request(8'h00, 8'd0);
      push_request(8'hff, 8'd0);
      push_request(HEAD_BYTE, 8'd0);
      frames_queued += 3;
      // escaped command, escaped payload with junk length
      push_request(ESC_BYTE, 8'd1);
      push_request(HEAD_BYTE, 8'hff);
      // run of escapes in the payload
      push_request(8'h3c, 8'd3);
      push_request(HEAD_BYTE, 8'h00);
      push_request(ESC_BYTE, 8'hff);
      push_request(HEAD_BYTE, 8'h01);
      // payload extremes and the neighbour of the escape codes
      push_request(8'ha5, 8'd4);
      push_request(8'h00, 8'h7f);
      push_request(8'hff, 8'h80);
      push_request(ESC_BYTE, 8'h00);
      push_request(ESC_ESC, HEAD_BYTE);
      frames_queued += 3;

      for (int ph = 0; ph < 8; ph++) begin
         // sender waits for the whole stream before registers change
         settle();
         case (ph)
            0: begin
               a = 8'hff; p = 8'hff; an = 8'hff; poly = 16'hffff;
            end
            1: begin
               a = HEAD_BYTE; p = 8'h00; an = ESC_BYTE; poly = 16'h0000;
            end
            2: begin
               a = ESC_BYTE; p = 8'h54; an = 8'h00; poly = 16'h8005;
            end
            default: begin
               a = pick_byte(); p = pick_byte(); an = pick_byte();
               poly = {pick_byte(), pick_byte()};
            end
         endcase
         // upper data bits of the byte registers carry junk
         write_reg(REG_BUS_ADDRESS, {8'($urandom), a});
         write_reg(REG_PRIORITY_CODE, {8'($urandom), p});
         write_reg(REG_ANSWER_CODE, {8'($urandom), an});
         write_reg(REG_CRC_POLYNOMIAL, poly);
         if (ph == 1) begin
            write_reg(REG_UNUSED, 16'hffff);
         end
         settings_done++;
         if (ph == 7) begin
            quiet = 1'b1;
         end
         if (ph == 4) begin
            // length byte wrapping to zero, and length plus one landing on the head code
            queue_frame(pick_byte(), 8'd255);
            queue_frame(pick_byte(), HEAD_BYTE - 8'd1);
         end
         target = requests_queued + 8;
         while (requests_queued < target) begin
            if ($urandom_range(0, 19) == 0) begin
               queue_frame(pick_byte(), 8'($urandom_range(13, 100)));
            end else begin
               queue_frame(pick_byte(), 8'($urandom_range(0, 12)));
            end
         end
      end

      settle();
      repeat (20) @(negedge clock);

      $display("Covered %0d requests in %0d frames under %0d register settings.",
               requests_queued, frames_queued, settings_done);
      $display("Compared %0d wire bytes with the predicted stream, %0d mismatches.",
               bytes_checked, err_cnt);
      if (err_cnt == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #30000000;
      $display("Timeout with %0d wire bytes outstanding.", wire_bytes_due.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ files.f @@
design/sce_pkg.sv
design/sce_req_if.sv
design/sce_rsp_if.sv
design/stuffed_crc_frame_encoder_top.sv
test/tb_stuffed_crc_frame_encoder_top.sv
